[hdl/livp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// livp_pkg
// Shared types and constants for the longest increasing weight path block.
// ----------------------------------------------------------------------------
package livp_pkg;

	localparam int NODE_COUNT_DEF  = 65536;
	localparam int WEIGHT_BITS_DEF = 17;
	localparam int LENGTH_BITS_DEF = 20;

	// epoch tag stored with every node entry; a full sweep runs on wrap
	localparam int EPOCH_BITS = 8;

	localparam int OUT_LENGTH_BITS = 20;
	localparam int OUT_LENGTH_MAX  = 1048575;

	// shared unit operations
	typedef logic [1:0] alu_op_t;
	localparam alu_op_t ALU_LT    = 2'd0;
	localparam alu_op_t ALU_EQ    = 2'd1;
	localparam alu_op_t ALU_INC   = 2'd2;
	localparam alu_op_t ALU_SUBGE = 2'd3;

	typedef struct packed {
		logic [15:0] source_node;
		logic [15:0] target_node;
		logic [16:0] edge_weight;
		logic        final_edge;
	} link_t;

	typedef struct packed {
		logic [OUT_LENGTH_BITS-1:0] longest_length;
		logic                       order_error;
	} result_t;

endpackage
`default_nettype wire

[hdl/livp_alu.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// livp_alu
// Shared compare / increment / conditional subtract unit for the sequencer.
// ----------------------------------------------------------------------------
module livp_alu
	import livp_pkg::*;
#(
	parameter int WIDTH       = 21,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  wire alu_op_t          op,
	input  wire logic [WIDTH-1:0] a,
	input  wire logic [WIDTH-1:0] b,
	output logic                  flag,
	output logic [WIDTH-1:0]      value
);

	localparam logic [WIDTH-1:0] LEN_MAX = WIDTH'((64'd1 << LENGTH_BITS) - 64'd1);

	always_comb begin
		flag  = 1'b0;
		value = a;
		case (op)
			ALU_LT: begin
				flag = (a < b);
			end
			ALU_EQ: begin
				flag = (a == b);
			end
			ALU_INC: begin
				// saturating increment at the length ceiling
				flag  = (a >= LEN_MAX);
				value = flag ? LEN_MAX : a + WIDTH'(1);
			end
			ALU_SUBGE: begin
				flag  = (a >= b);
				value = flag ? a - b : a;
			end
			default: begin
				flag  = 1'b0;
				value = a;
			end
		endcase
	end

endmodule
`default_nettype wire

[hdl/livp_node_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// livp_node_ram
// Per-node store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module livp_node_ram #(
	parameter int DEPTH     = 65536,
	parameter int ADDR_BITS = 16,
	parameter int WIDTH     = 66
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [ADDR_BITS-1:0] waddr,
	input  wire logic [WIDTH-1:0]     wdata,
	input  wire logic                 re,
	input  wire logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

[hdl/longest_increasing_weight_path.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// longest_increasing_weight_path
// Streams directed edges in nondecreasing weight order and reports the
// longest path whose edge weights strictly increase.
// ----------------------------------------------------------------------------
// link channel (link_valid / link_stall / link): one edge per transfer.
// result channel (result_valid / result_stall / result): one result after
// each edge flagged final_edge, with the saturated longest length and a
// sticky order error flag.
// Processing: link_stall stays high until an edge is through, with an output
//   state for a final edge and index reduction when NODE_COUNT is not a power
//   of two and below 65536; one store port each way, one shared unit.
// Output: result_valid rises when the output state loads the result into the
//   output register, provided that register is free.
// Reset: a clearing pass writes every node entry with link_stall high; the
//   same pass runs after every 2^EPOCH_BITS graphs.
// Stall: the result waits in an output register while the next graph's edges
//   are taken; a second final edge waits until it has gone.
// ----------------------------------------------------------------------------
module longest_increasing_weight_path
	import livp_pkg::*;
#(
	parameter int NODE_COUNT  = NODE_COUNT_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    link_valid,
	output logic         link_stall,
	input  wire link_t   link,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);

	localparam int ADDR_BITS = $clog2(NODE_COUNT);
	localparam bit NODE_POW2 = ((NODE_COUNT & (NODE_COUNT - 1)) == 0);
	localparam bit MOD_NEEDED = !NODE_POW2 && (NODE_COUNT < 65536);

	localparam int AW_0 = (WEIGHT_BITS > LENGTH_BITS) ? WEIGHT_BITS : LENGTH_BITS;
	localparam int AW_1 = (AW_0 > ADDR_BITS + 1) ? AW_0 : ADDR_BITS + 1;
	localparam int AW   = (AW_1 > 16) ? AW_1 : 16;
	localparam int OW   = (LENGTH_BITS > OUT_LENGTH_BITS) ? LENGTH_BITS : OUT_LENGTH_BITS;

	// reciprocal for index reduction: exact quotient for any 16-bit index
	localparam int MOD_SHIFT = 16 + ADDR_BITS;
	localparam logic [16:0] MOD_RECIP =
		17'(((64'd1 << MOD_SHIFT) + 64'(NODE_COUNT) - 64'd1) / 64'(NODE_COUNT));

	// node entry layout
	localparam int LEN_LO    = 0;
	localparam int BEF_LO    = LENGTH_BITS;
	localparam int GW_LO     = 2 * LENGTH_BITS;
	localparam int VAL_BIT   = 2 * LENGTH_BITS + WEIGHT_BITS;
	localparam int EP_LO     = VAL_BIT + 1;
	localparam int WORD_BITS = EP_LO + EPOCH_BITS;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_MSRC  = 4'd2;
	localparam logic [3:0] S_MTGT  = 4'd3;
	localparam logic [3:0] S_ORD   = 4'd4;
	localparam logic [3:0] S_SEQ   = 4'd5;
	localparam logic [3:0] S_TEQ   = 4'd6;
	localparam logic [3:0] S_INC   = 4'd7;
	localparam logic [3:0] S_MAX   = 4'd8;
	localparam logic [3:0] S_BEST  = 4'd9;
	localparam logic [3:0] S_OUT   = 4'd10;

	logic [3:0]             state_q;
	logic [ADDR_BITS-1:0]   clr_q;
	logic [EPOCH_BITS-1:0]  epoch_q;

	logic [15:0]            src_raw_q;
	logic [15:0]            tgt_raw_q;
	logic                   mod_ph_q;
	logic [15:0]            quo_q;
	logic [ADDR_BITS-1:0]   src_idx_q;
	logic [ADDR_BITS-1:0]   tgt_idx_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic                   last_q;

	logic [WEIGHT_BITS-1:0] prev_w_q;
	logic                   seen_q;
	logic                   fault_q;
	logic [LENGTH_BITS-1:0] best_q;

	logic [LENGTH_BITS-1:0] src_len_q;
	logic [LENGTH_BITS-1:0] tgt_len_q;
	logic [LENGTH_BITS-1:0] tgt_bef_q;
	logic [WEIGHT_BITS-1:0] tgt_gw_q;
	logic [LENGTH_BITS-1:0] offer_q;
	logic [LENGTH_BITS-1:0] newlen_q;

	logic                   result_valid_q;
	result_t                result_q;

	// index reduction
	logic [15:0]            mod_x;
	logic [32:0]            mod_prod;
	logic [15:0]            mod_quo;
	logic [31:0]            mod_back;

	// node store
	logic                   ram_we;
	logic [ADDR_BITS-1:0]   ram_waddr;
	logic [WORD_BITS-1:0]   ram_wdata;
	logic                   ram_re;
	logic [ADDR_BITS-1:0]   ram_raddr;
	logic [WORD_BITS-1:0]   ram_rdata;

	logic [LENGTH_BITS-1:0] rd_len;
	logic [LENGTH_BITS-1:0] rd_bef;
	logic [WEIGHT_BITS-1:0] rd_gw;
	logic                   rd_val;
	logic                   rd_live;
	logic [LENGTH_BITS-1:0] rd_len_live;

	// shared unit
	alu_op_t                alu_op;
	logic [AW-1:0]          alu_a;
	logic [AW-1:0]          alu_b;
	logic                   alu_flag;
	logic [AW-1:0]          alu_value;

	logic [OW-1:0]          best_ext;
	logic [OUT_LENGTH_BITS-1:0] best_out;
	logic                   out_free;

	livp_node_ram #(
		.DEPTH     (NODE_COUNT),
		.ADDR_BITS (ADDR_BITS),
		.WIDTH     (WORD_BITS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	livp_alu #(
		.WIDTH       (AW),
		.LENGTH_BITS (LENGTH_BITS)
	) u_alu (
		.op    (alu_op),
		.a     (alu_a),
		.b     (alu_b),
		.flag  (alu_flag),
		.value (alu_value)
	);

	assign rd_len  = ram_rdata[LEN_LO +: LENGTH_BITS];
	assign rd_bef  = ram_rdata[BEF_LO +: LENGTH_BITS];
	assign rd_gw   = ram_rdata[GW_LO +: WEIGHT_BITS];
	assign rd_val  = ram_rdata[VAL_BIT];
	// an entry from an older graph reads as cleared
	assign rd_live = (ram_rdata[EP_LO +: EPOCH_BITS] == epoch_q);
	assign rd_len_live = rd_live ? rd_len : '0;

	assign mod_x    = (state_q == S_MTGT) ? tgt_raw_q : src_raw_q;
	assign mod_prod = 33'(mod_x) * 33'(MOD_RECIP);
	assign mod_quo  = 16'(mod_prod >> MOD_SHIFT);
	assign mod_back = 32'(quo_q) * 32'(NODE_COUNT);

	assign best_ext = OW'(best_q);
	assign best_out = (best_ext > OW'(OUT_LENGTH_MAX)) ? OUT_LENGTH_BITS'(OUT_LENGTH_MAX)
	                                                   : best_ext[OUT_LENGTH_BITS-1:0];
	assign out_free = !result_valid_q || !result_stall;

	always_comb begin
		alu_op = ALU_LT;
		alu_a  = '0;
		alu_b  = '0;
		case (state_q)
			S_MSRC, S_MTGT: begin
				alu_op = ALU_SUBGE;
				alu_a  = AW'(mod_x);
				alu_b  = AW'(mod_back);
			end
			S_ORD: begin
				alu_op = ALU_LT;
				alu_a  = AW'(w_q);
				alu_b  = AW'(prev_w_q);
			end
			S_SEQ, S_TEQ: begin
				alu_op = ALU_EQ;
				alu_a  = AW'(rd_gw);
				alu_b  = AW'(w_q);
			end
			S_INC: begin
				alu_op = ALU_INC;
				alu_a  = AW'(src_len_q);
			end
			S_MAX: begin
				alu_op = ALU_LT;
				alu_a  = AW'(tgt_len_q);
				alu_b  = AW'(offer_q);
			end
			S_BEST: begin
				alu_op = ALU_LT;
				alu_a  = AW'(best_q);
				alu_b  = AW'(newlen_q);
			end
			default: begin
				alu_op = ALU_LT;
				alu_a  = '0;
				alu_b  = '0;
			end
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = tgt_idx_q;
		ram_wdata = {epoch_q, 1'b1, tgt_gw_q, tgt_bef_q,
		             alu_flag ? offer_q : tgt_len_q};
		ram_re    = 1'b0;
		ram_raddr = src_idx_q;
		case (state_q)
			S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_ORD: begin
				ram_re    = 1'b1;
				ram_raddr = src_idx_q;
			end
			S_SEQ: begin
				ram_re    = 1'b1;
				ram_raddr = tgt_idx_q;
			end
			S_MAX: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
				ram_re = 1'b0;
			end
		endcase
	end

	assign link_stall   = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLR;
			clr_q          <= '0;
			epoch_q        <= '0;
			prev_w_q       <= '0;
			seen_q         <= 1'b0;
			fault_q        <= 1'b0;
			best_q         <= '0;
			result_valid_q <= 1'b0;
			mod_ph_q       <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					if (clr_q == ADDR_BITS'(NODE_COUNT - 1)) begin
						clr_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + ADDR_BITS'(1);
					end
				end
				S_IDLE: begin
					if (link_valid) begin
						src_raw_q <= link.source_node;
						tgt_raw_q <= link.target_node;
						w_q       <= WEIGHT_BITS'(link.edge_weight);
						last_q    <= link.final_edge;
						if (MOD_NEEDED) begin
							state_q <= S_MSRC;
						end else begin
							src_idx_q <= ADDR_BITS'(link.source_node);
							tgt_idx_q <= ADDR_BITS'(link.target_node);
							state_q   <= S_ORD;
						end
					end
				end
				// index reduction: quotient by reciprocal, then subtract back
				S_MSRC: begin
					if (!mod_ph_q) begin
						quo_q    <= mod_quo;
						mod_ph_q <= 1'b1;
					end else begin
						src_idx_q <= alu_value[ADDR_BITS-1:0];
						mod_ph_q  <= 1'b0;
						state_q   <= S_MTGT;
					end
				end
				S_MTGT: begin
					if (!mod_ph_q) begin
						quo_q    <= mod_quo;
						mod_ph_q <= 1'b1;
					end else begin
						tgt_idx_q <= alu_value[ADDR_BITS-1:0];
						mod_ph_q  <= 1'b0;
						state_q   <= S_ORD;
					end
				end
				S_ORD: begin
					fault_q  <= fault_q | (seen_q & alu_flag);
					prev_w_q <= w_q;
					seen_q   <= 1'b1;
					state_q  <= S_SEQ;
				end
				S_SEQ: begin
					// source length as it stood before this weight group
					src_len_q <= (rd_live && rd_val && alu_flag) ? rd_bef : rd_len_live;
					state_q   <= S_TEQ;
				end
				S_TEQ: begin
					tgt_len_q <= rd_len_live;
					if (rd_live && rd_val && alu_flag) begin
						tgt_bef_q <= rd_bef;
						tgt_gw_q  <= rd_gw;
					end else begin
						tgt_bef_q <= rd_len_live;
						tgt_gw_q  <= w_q;
					end
					state_q <= S_INC;
				end
				S_INC: begin
					offer_q <= alu_value[LENGTH_BITS-1:0];
					state_q <= S_MAX;
				end
				S_MAX: begin
					newlen_q <= alu_flag ? offer_q : tgt_len_q;
					state_q  <= S_BEST;
				end
				S_BEST: begin
					if (alu_flag) begin
						best_q <= newlen_q;
					end
					state_q <= last_q ? S_OUT : S_IDLE;
				end
				S_OUT: begin
					if (out_free) begin
						result_q.longest_length <= best_out;
						result_q.order_error    <= fault_q;
						prev_w_q                <= '0;
						seen_q                  <= 1'b0;
						fault_q                 <= 1'b0;
						best_q                  <= '0;
						epoch_q                 <= epoch_q + EPOCH_BITS'(1);
						// tag wrap: old entries could alias, sweep the store
						if (epoch_q == {EPOCH_BITS{1'b1}}) begin
							clr_q   <= '0;
							state_q <= S_CLR;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	// a result is only loaded from the output state
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !$past(result_valid)) |-> ($past(state_q) == S_OUT))
		else $error("result raised outside output state");

	// store writes stay inside the node range
	a_waddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (ram_waddr <= ADDR_BITS'(NODE_COUNT - 1)))
		else $error("node store write beyond range");

	// reduced indices are in range when the store is first read
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ORD) |-> ((src_idx_q <= ADDR_BITS'(NODE_COUNT - 1)) &&
		                        (tgt_idx_q <= ADDR_BITS'(NODE_COUNT - 1))))
		else $error("node index out of range");

	// a transfer on the link channel starts processing
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(link_valid && !link_stall) |=> link_stall)
		else $error("edge taken without processing");
`endif

endmodule
`default_nettype wire
